### rtl/ysq_pkg.sv
// Types and codes shared by the YMODEM send sequencer modules.
`default_nettype none
package ysq_pkg;

  typedef struct packed {
    logic               kind;
    logic signed [11:0] write_length;
    logic [2:0]         response_code;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  send_action;
    logic [7:0]  frame_block_number;
    logic        call_done;
    logic [2:0]  call_status;
    logic [10:0] done_length;
  } out_item_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_HDR_C1  = 3'd1,
    PH_HDR_ACK = 3'd2,
    PH_HDR_C2  = 3'd3,
    PH_BLK_ACK = 3'd4,
    PH_EOT_ACK = 3'd5,
    PH_NUL_C   = 3'd6,
    PH_NUL_ACK = 3'd7
  } phase_t;

  typedef struct packed {
    phase_t     phase;
    logic       header_sent;
    logic [7:0] block_count;
  } core_status_t;

  localparam logic KIND_WRITE = 1'b0;

  localparam logic [2:0] ACT_NONE = 3'd0;
  localparam logic [2:0] ACT_SOH  = 3'd1;
  localparam logic [2:0] ACT_STX  = 3'd2;
  localparam logic [2:0] ACT_EOT  = 3'd3;
  localparam logic [2:0] ACT_CAN  = 3'd4;

  localparam logic [2:0] RSP_C    = 3'd0;
  localparam logic [2:0] RSP_ACK  = 3'd1;
  localparam logic [2:0] RSP_CAN  = 3'd3;
  localparam logic [2:0] RSP_TMO  = 3'd4;
  localparam logic [2:0] RSP_LINK = 3'd5;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_CALL = 3'd1;
  localparam logic [2:0] ST_CANCEL   = 3'd2;
  localparam logic [2:0] ST_TIMEOUT  = 3'd3;
  localparam logic [2:0] ST_LINK     = 3'd4;

  localparam logic       REG_DRIVER_OPEN  = 1'b0;
  localparam logic       REG_HEADER_LIMIT = 1'b1;
  localparam logic [10:0] HEADER_LIMIT_RESET = 11'd128;

endpackage
`default_nettype wire

### rtl/ysq_core.sv
// Protocol state registers and per-transaction next-state and result logic.
`default_nettype none
module ysq_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             fire,
  input  wire ysq_pkg::in_item_t item,
  input  wire logic             driver_open,
  input  wire logic [10:0]      header_length_limit,
  output logic                  res_valid,
  output ysq_pkg::out_item_t    res,
  output ysq_pkg::core_status_t status
);
  import ysq_pkg::*;

  phase_t      phase, phase_next;
  logic        header_sent, header_sent_next;
  logic [7:0]  block_count, block_count_next;
  logic [10:0] pending_length, pending_length_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      header_sent    <= 1'b0;
      block_count    <= 8'd0;
      pending_length <= 11'd0;
    end else begin
      phase          <= phase_next;
      header_sent    <= header_sent_next;
      block_count    <= block_count_next;
      pending_length <= pending_length_next;
    end
  end

  always_comb begin
    logic [2:0] code;
    logic       end_seq;
    logic       early;
    code                = item.response_code;
    end_seq             = (phase == PH_EOT_ACK) || (phase == PH_NUL_C) || (phase == PH_NUL_ACK);
    early               = (phase == PH_HDR_C1) || (phase == PH_HDR_ACK);
    phase_next          = phase;
    header_sent_next    = header_sent;
    block_count_next    = block_count;
    pending_length_next = pending_length;
    res_valid           = 1'b0;
    res                 = '0;
    if (fire) begin
      if (item.kind == KIND_WRITE) begin
        if (phase == PH_IDLE) begin
          if (!driver_open || item.write_length[11]) begin
            res_valid       = 1'b1;
            res.call_done   = 1'b1;
            res.call_status = ST_BAD_CALL;
          end else if (item.write_length == 12'sd0) begin
            res_valid     = 1'b1;
            res.call_done = 1'b1;
          end else begin
            pending_length_next = item.write_length[10:0];
            if (!header_sent) begin
              phase_next = PH_HDR_C1;
            end else if (item.write_length[10:0] > header_length_limit) begin
              block_count_next       = block_count + 8'd1;
              phase_next             = PH_BLK_ACK;
              res_valid              = 1'b1;
              res.send_action        = ACT_STX;
              res.frame_block_number = block_count + 8'd1;
            end else begin
              phase_next      = PH_EOT_ACK;
              res_valid       = 1'b1;
              res.send_action = ACT_EOT;
            end
          end
        end
      end else if (phase != PH_IDLE) begin
        if (code inside {RSP_CAN, RSP_TMO, RSP_LINK}) begin
          if (code == RSP_CAN || code == RSP_TMO || early) begin
            header_sent_next = 1'b0;
            block_count_next = 8'd0;
          end
          if (end_seq) begin
            header_sent_next = 1'b0;
          end
          phase_next      = PH_IDLE;
          res_valid       = 1'b1;
          res.call_done   = 1'b1;
          res.send_action = (code == RSP_TMO) ? ACT_CAN : ACT_NONE;
          if (end_seq) begin
            res.done_length = pending_length;
          end else begin
            case (code)
              RSP_CAN: res.call_status = ST_CANCEL;
              RSP_TMO: res.call_status = ST_TIMEOUT;
              default: res.call_status = ST_LINK;
            endcase
          end
        end else begin
          case (phase)
            PH_HDR_C1, PH_NUL_C: begin
              if (code == RSP_C) begin
                block_count_next = 8'd0;
                phase_next       = (phase == PH_HDR_C1) ? PH_HDR_ACK : PH_NUL_ACK;
                res_valid        = 1'b1;
                res.send_action  = ACT_SOH;
              end
            end
            PH_HDR_ACK: begin
              if (code == RSP_ACK) begin
                phase_next = PH_HDR_C2;
              end else begin
                res_valid       = 1'b1;
                res.send_action = ACT_SOH;
              end
            end
            PH_HDR_C2: begin
              if (code == RSP_C) begin
                header_sent_next = 1'b1;
                phase_next       = PH_IDLE;
                res_valid        = 1'b1;
                res.call_done    = 1'b1;
                res.done_length  = pending_length;
              end
            end
            PH_BLK_ACK: begin
              res_valid = 1'b1;
              if (code == RSP_ACK) begin
                phase_next      = PH_IDLE;
                res.call_done   = 1'b1;
                res.done_length = pending_length;
              end else begin
                res.send_action        = ACT_STX;
                res.frame_block_number = block_count;
              end
            end
            PH_EOT_ACK: begin
              if (code == RSP_ACK) begin
                phase_next = PH_NUL_C;
              end else begin
                res_valid       = 1'b1;
                res.send_action = ACT_EOT;
              end
            end
            PH_NUL_ACK: begin
              res_valid = 1'b1;
              if (code == RSP_ACK) begin
                header_sent_next = 1'b0;
                phase_next       = PH_IDLE;
                res.call_done    = 1'b1;
                res.done_length  = pending_length;
              end else begin
                res.send_action = ACT_SOH;
              end
            end
            default: begin
            end
          endcase
        end
      end
    end
  end

  assign status = '{phase: phase, header_sent: header_sent, block_count: block_count};

endmodule
`default_nettype wire

### rtl/ysq_out_reg.sv
// Result register on the output channel.
`default_nettype none
module ysq_out_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire ysq_pkg::out_item_t push_item,
  output logic                   ready,
  output logic                   valid,
  input  wire logic              stall,
  output ysq_pkg::out_item_t     data
);
  import ysq_pkg::*;

  assign ready = !valid || !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready) begin
      valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && push) begin
      data <= push_item;
    end
  end

endmodule
`default_nettype wire

### rtl/ymodem_send_sequencer.sv
// YMODEM send sequencer: control path that orders frames and completes write calls.
//
// Input channel (in_valid/in_stall/in_data) carries one transaction per write
// request or classified receiver response. Output channel (out_valid/out_stall/
// out_data) carries zero or one result per input transaction, in order.
// Configuration (driver_open, header_length_limit) is written over the APB port
// at byte addresses 0 and 4; the user must write it only while the block is
// idle, which the block itself does not enforce. pready is always high.
// An accepted input goes to the input register; its result goes to the result
// register, from which it drives out_valid. Throughput: one input transaction
// per cycle while the output is not stalled, one state step per transaction.
// Reset: protocol phase idle, header flag and block number cleared, driver
// closed, header length limit 128; no output is pending.
// Stall: while the result register is full and stalled, one more input
// transaction is held in the input register; after that in_stall rises.
// A timeout result orders a CAN send action (ACT_CAN).
`default_nettype none
module ymodem_send_sequencer (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire ysq_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output ysq_pkg::out_item_t     out_data
);
  import ysq_pkg::*;

  logic         driver_open;
  logic [10:0]  header_length_limit;
  logic         s1_valid;
  in_item_t     s1_item;
  logic         out_ready;
  logic         fire;
  logic         res_valid;
  out_item_t    res;
  core_status_t status;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      driver_open         <= 1'b0;
      header_length_limit <= HEADER_LIMIT_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_DRIVER_OPEN:  driver_open         <= pwdata[0];
        REG_HEADER_LIMIT: header_length_limit <= pwdata[10:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_DRIVER_OPEN:  prdata = {31'd0, driver_open};
      REG_HEADER_LIMIT: prdata = {21'd0, header_length_limit};
      default:          prdata = '0;
    endcase
  end

  assign fire     = s1_valid && out_ready;
  assign in_stall = s1_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item <= in_data;
    end
  end

  ysq_core u_core (
    .clk                 (clk),
    .rst                 (rst),
    .fire                (fire),
    .item                (s1_item),
    .driver_open         (driver_open),
    .header_length_limit (header_length_limit),
    .res_valid           (res_valid),
    .res                 (res),
    .status              (status)
  );

  ysq_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (fire && res_valid),
    .push_item (res),
    .ready     (out_ready),
    .valid     (out_valid),
    .stall     (out_stall),
    .data      (out_data)
  );

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_stall_needs_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid)
    else $error("input stalled with free stages");

  a_blk_only_stx: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.send_action != ACT_STX) |-> out_data.frame_block_number == 8'd0)
    else $error("block number on non-STX result");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    fire && res_valid && res.call_done |=> status.phase == PH_IDLE)
    else $error("call completed but phase not idle");

  a_bad_call_idle: assert property (@(posedge clk) disable iff (rst)
    fire && res_valid && (res.call_status == ST_BAD_CALL) |-> status.phase == PH_IDLE)
    else $error("rejected call while busy");

endmodule
`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for the YMODEM send sequencer: directed table, then guided random.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ysq_pkg::*;

  localparam logic [2:0] RSP_OTHER  = 3'd2;
  localparam logic [2:0] RSP_SPARE6 = 3'd6;
  localparam logic [2:0] RSP_SPARE7 = 3'd7;
  localparam int         DRAIN_CYCLES = 4;

  typedef struct packed {
    logic        is_cfg;
    logic        pinned;
    logic        pin_has;
    in_item_t    item;
    out_item_t   pin_res;
    logic        cfg_reg;
    logic [10:0] cfg_val;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  wire  [31:0] prdata;
  wire         pready;
  logic        in_valid;
  wire         in_stall;
  in_item_t    in_data;
  wire         out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;

  ymodem_send_sequencer DUT (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state and register shadow
  phase_t      ph;
  logic        hdr_sent;
  logic [7:0]  blk_num;
  logic [10:0] pend_len;
  logic        drv_open;
  logic [10:0] hdr_limit;

  out_item_t   awaited_orders[$];
  int          mismatch_count = 0;
  bit          quiet = 1'b0;
  int          stall_left = 0;
  dir_row_t    dir_rows[$];

  function automatic bit predict_order(input in_item_t it, output out_item_t res,
                                       output bit moved);
    logic [11:0] raw;
    logic [2:0]  code;
    bit          end_seq, early;
    res   = '0;
    moved = 1'b1;
    raw   = it.write_length;
    code  = it.response_code;
    if (it.kind == KIND_WRITE) begin
      if (ph != PH_IDLE) begin
        moved = 1'b0;
        return 1'b0;
      end
      if (!drv_open || raw[11]) begin
        res.call_done   = 1'b1;
        res.call_status = ST_BAD_CALL;
        return 1'b1;
      end
      if (raw == '0) begin
        res.call_done = 1'b1;
        return 1'b1;
      end
      pend_len = raw[10:0];
      if (!hdr_sent) begin
        ph = PH_HDR_C1;
        return 1'b0;
      end
      if (raw[10:0] > hdr_limit) begin
        blk_num = blk_num + 8'd1;
        ph = PH_BLK_ACK;
        res.send_action        = ACT_STX;
        res.frame_block_number = blk_num;
        return 1'b1;
      end
      ph = PH_EOT_ACK;
      res.send_action = ACT_EOT;
      return 1'b1;
    end
    if (ph == PH_IDLE) begin
      moved = 1'b0;
      return 1'b0;
    end
    if (code == RSP_CAN || code == RSP_TMO || code == RSP_LINK) begin
      end_seq = (ph == PH_EOT_ACK || ph == PH_NUL_C || ph == PH_NUL_ACK);
      early   = (ph == PH_HDR_C1 || ph == PH_HDR_ACK);
      if (code == RSP_CAN || code == RSP_TMO || early) begin
        hdr_sent = 1'b0;
        blk_num  = '0;
      end
      if (code == RSP_TMO) res.send_action = ACT_CAN;
      if (end_seq) hdr_sent = 1'b0;
      ph = PH_IDLE;
      res.call_done = 1'b1;
      if (end_seq) res.done_length = pend_len;
      else if (code == RSP_CAN) res.call_status = ST_CANCEL;
      else if (code == RSP_TMO) res.call_status = ST_TIMEOUT;
      else res.call_status = ST_LINK;
      return 1'b1;
    end
    case (ph)
      PH_HDR_C1, PH_NUL_C: begin
        if (code != RSP_C) begin
          moved = 1'b0;
          return 1'b0;
        end
        blk_num = '0;
        if (ph == PH_HDR_C1) ph = PH_HDR_ACK;
        else ph = PH_NUL_ACK;
        res.send_action = ACT_SOH;
        return 1'b1;
      end
      PH_HDR_ACK: begin
        if (code != RSP_ACK) begin
          res.send_action = ACT_SOH;
          return 1'b1;
        end
        ph = PH_HDR_C2;
        return 1'b0;
      end
      PH_HDR_C2: begin
        if (code != RSP_C) begin
          moved = 1'b0;
          return 1'b0;
        end
        hdr_sent = 1'b1;
        ph = PH_IDLE;
        res.call_done   = 1'b1;
        res.done_length = pend_len;
        return 1'b1;
      end
      PH_BLK_ACK: begin
        if (code != RSP_ACK) begin
          res.send_action        = ACT_STX;
          res.frame_block_number = blk_num;
          return 1'b1;
        end
        ph = PH_IDLE;
        res.call_done   = 1'b1;
        res.done_length = pend_len;
        return 1'b1;
      end
      PH_EOT_ACK: begin
        if (code != RSP_ACK) begin
          res.send_action = ACT_EOT;
          return 1'b1;
        end
        ph = PH_NUL_C;
        return 1'b0;
      end
      default: begin
        if (code != RSP_ACK) begin
          res.send_action = ACT_SOH;
          return 1'b1;
        end
        hdr_sent = 1'b0;
        ph = PH_IDLE;
        res.call_done   = 1'b1;
        res.done_length = pend_len;
        return 1'b1;
      end
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // mostly well-formed traffic for the current wait phase, with some noise
  function automatic in_item_t pick_item(input int err_pct, input int short_pct,
                                         input int noise_pct);
    in_item_t it;
    int       r;
    it = in_item_t'(16'($urandom));
    if ($urandom_range(99) < noise_pct) return it;
    r = $urandom_range(99);
    if (ph == PH_IDLE) begin
      it.kind = KIND_WRITE;
      if (r < 4) it.write_length = '0;
      else if (r < 8) it.write_length = {1'b1, 11'($urandom)};
      else if (r < 8 + short_pct)
        it.write_length = 12'($urandom_range(hdr_limit > 0 ? hdr_limit : 1, 1));
      else
        it.write_length = 12'($urandom_range(2047, hdr_limit + 1));
    end else begin
      it.kind = ~KIND_WRITE;
      if (r < 3) it.kind = KIND_WRITE;
      else if (r < 3 + err_pct) begin
        case ($urandom_range(2))
          0: it.response_code = RSP_CAN;
          1: it.response_code = RSP_TMO;
          default: it.response_code = RSP_LINK;
        endcase
      end else if (r < 13 + err_pct) begin
        case ($urandom_range(4))
          0: it.response_code = RSP_C;
          1: it.response_code = RSP_ACK;
          2: it.response_code = RSP_SPARE6;
          3: it.response_code = RSP_SPARE7;
          default: it.response_code = RSP_OTHER;
        endcase
      end else if (ph == PH_HDR_C1 || ph == PH_HDR_C2 || ph == PH_NUL_C)
        it.response_code = RSP_C;
      else
        it.response_code = RSP_ACK;
    end
    return it;
  endfunction

  function automatic dir_row_t row_write(input int len);
    dir_row_t r;
    r = '0;
    r.item.kind = KIND_WRITE;
    r.item.write_length = 12'(len);
    return r;
  endfunction

  function automatic dir_row_t row_rsp(input logic [2:0] code);
    dir_row_t r;
    r = '0;
    r.item.kind = ~KIND_WRITE;
    r.item.response_code = code;
    return r;
  endfunction

  function automatic dir_row_t row_cfg(input logic sel, input logic [10:0] val);
    dir_row_t r;
    r = '0;
    r.is_cfg  = 1'b1;
    r.cfg_reg = sel;
    r.cfg_val = val;
    return r;
  endfunction

  // expected completion typed in by hand; has=0 means no result at all
  function automatic dir_row_t pinned(input dir_row_t r, input logic has,
                                      input logic [2:0] act, input logic [2:0] st,
                                      input logic [10:0] len);
    r.pinned  = 1'b1;
    r.pin_has = has;
    r.pin_res = '0;
    if (has) begin
      r.pin_res.send_action = act;
      r.pin_res.call_done   = 1'b1;
      r.pin_res.call_status = st;
      r.pin_res.done_length = len;
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("%0t MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_order(input out_item_t got);
    out_item_t want;
    if (awaited_orders.size() == 0) begin
      flag_mismatch("unexpected result, send_action", got.send_action, -1);
      return;
    end
    want = awaited_orders.pop_front();
    if (got.send_action != want.send_action)
      flag_mismatch("send_action", got.send_action, want.send_action);
    if (got.frame_block_number != want.frame_block_number)
      flag_mismatch("frame_block_number", got.frame_block_number, want.frame_block_number);
    if (got.call_done != want.call_done)
      flag_mismatch("call_done", got.call_done, want.call_done);
    if (got.call_status != want.call_status)
      flag_mismatch("call_status", got.call_status, want.call_status);
    if (got.done_length != want.done_length)
      flag_mismatch("done_length", got.done_length, want.done_length);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_order(out_data);
      if (stall_left == 0 && !quiet && $urandom_range(99) < 12) stall_left = pick_gap() + 1;
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_item(input in_item_t it, input int gap, input logic pin,
                           input logic pin_has, input out_item_t pin_res, output bit took);
    out_item_t res;
    bit        has;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    has = predict_order(it, res, took);
    if (pin) begin
      if (pin_has) awaited_orders.push_back(pin_res);
    end else if (has) begin
      awaited_orders.push_back(res);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic stop_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    stop_input();
    while (awaited_orders.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic sel, input logic [31:0] val);
    paddr   <= {sel, 2'b00};
    pwdata  <= val;
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (sel == REG_DRIVER_OPEN) drv_open = val[0];
    else hdr_limit = val[10:0];
    @(posedge clk);
  endtask

  initial begin
    #10ms;
    $display("testbench: done, errors");
    $finish;
  end

  initial begin
    dir_row_t  row;
    in_item_t  it;
    bit        took;
    bit        paused;
    int        count, done_items, err_pct, short_pct, noise_pct;
    logic [10:0] lim;

    rst      = 1'b1;
    in_valid = 1'b0;
    in_data  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    ph        = PH_IDLE;
    hdr_sent  = 1'b0;
    blk_num   = '0;
    pend_len  = '0;
    drv_open  = 1'b0;
    hdr_limit = HEADER_LIMIT_RESET;

    dir_rows = '{
      pinned(row_write(100), 1'b1, ACT_NONE, ST_BAD_CALL, 11'd0),
      pinned(row_rsp(RSP_C), 1'b0, ACT_NONE, ST_OK, 11'd0),
      row_cfg(REG_DRIVER_OPEN, 11'd1),
      pinned(row_write(-1), 1'b1, ACT_NONE, ST_BAD_CALL, 11'd0),
      pinned(row_write(-2048), 1'b1, ACT_NONE, ST_BAD_CALL, 11'd0),
      pinned(row_write(0), 1'b1, ACT_NONE, ST_OK, 11'd0),
      row_write(2047),
      row_write(5),
      row_rsp(RSP_ACK),
      row_rsp(RSP_C),
      row_rsp(RSP_OTHER),
      row_rsp(RSP_C),
      row_rsp(RSP_ACK),
      row_rsp(RSP_SPARE7),
      row_rsp(RSP_C),
      row_cfg(REG_HEADER_LIMIT, 11'd0),
      row_write(1),
      row_rsp(RSP_SPARE6),
      row_rsp(RSP_ACK),
      row_write(1),
      pinned(row_rsp(RSP_LINK), 1'b1, ACT_NONE, ST_LINK, 11'd0),
      row_cfg(REG_HEADER_LIMIT, 11'd1024),
      row_write(1024),
      row_rsp(RSP_ACK),
      row_rsp(RSP_C),
      row_rsp(RSP_LINK),
      row_write(9),
      pinned(row_rsp(RSP_TMO), 1'b1, ACT_CAN, ST_TIMEOUT, 11'd0),
      row_write(3),
      row_rsp(RSP_C),
      pinned(row_rsp(RSP_CAN), 1'b1, ACT_NONE, ST_CANCEL, 11'd0)
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.is_cfg) begin
        settle();
        cfg_write(row.cfg_reg, 32'(row.cfg_val));
      end else begin
        send_item(row.item, pick_gap(), row.pinned, row.pin_has, row.pin_res, took);
      end
    end

    // phase 1 is a long run of data blocks so the block number wraps
    for (int p = 0; p < 8; p++) begin
      settle();
      case (p)
        0: lim = 11'd1024;
        1, 3: lim = 11'd0;
        default: lim = 11'($urandom_range(1023, 1));
      endcase
      cfg_write(REG_HEADER_LIMIT, 32'(lim));
      cfg_write(REG_DRIVER_OPEN, (p == 5) ? 32'd0 : 32'd1);
      count     = (p == 1) ? 650 : (p == 5) ? 40 : 110;
      err_pct   = (p == 1) ? 0 : 4;
      noise_pct = (p == 1) ? 0 : 4;
      short_pct = 30;
      done_items = 0;
      paused     = 1'b0;
      quiet      = (p % 3 == 0);
      while (done_items < count) begin
        if (quiet && done_items >= 60) quiet = 1'b0;
        if (!paused && done_items >= count / 2) begin
          paused = 1'b1;
          settle();
        end
        it = pick_item(err_pct, short_pct, noise_pct);
        send_item(it, quiet ? 0 : pick_gap(), 1'b0, 1'b0, '0, took);
        if (took) done_items++;
      end
    end

    quiet = 1'b1;
    stop_input();
    while (awaited_orders.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule

### files.f
rtl/ysq_pkg.sv
rtl/ysq_core.sv
rtl/ysq_out_reg.sv
rtl/ymodem_send_sequencer.sv
tb/testbench.sv
